// File: rtl/eti_pkg.sv
// ----------------------------------------------------------------------------
// eti_pkg
// Shared widths, constants and helpers of the escape-time iterator.
// ----------------------------------------------------------------------------
package eti_pkg;

  localparam int FracBits = 28;
  localparam int CoordW   = 32;
  localparam int CW       = 31;
  localparam int CntW     = 16;
  localparam int ProdW    = 2 * CoordW;
  localparam int SumW     = ProdW + 2;

  localparam int EscBits  = 2 * FracBits + 2;
  localparam bit EscNever = (EscBits >= ProdW);
  localparam logic [ProdW-1:0] EscLimit =
      EscNever ? '1 : (ProdW'(1) << (EscBits % ProdW));

  localparam int InTdataW  = ((2 * CW + 7) / 8) * 8;
  localparam int OutTdataW = ((CntW + 2 * CoordW + 7) / 8) * 8;

  localparam int RegIdxW = 1;
  localparam int PaddrW  = RegIdxW + 2;
  localparam int PdataW  = 32;

  localparam logic [RegIdxW-1:0] RegMaxIter  = RegIdxW'(0);
  localparam logic [CntW-1:0]    MaxIterInit = CntW'(256);

  localparam logic signed [SumW-1:0] SatHi = SumW'((64'sd1 <<< (CoordW - 1)) - 64'sd1);
  localparam logic signed [SumW-1:0] SatLo = -SumW'(64'sd1 <<< (CoordW - 1));

  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [SumW-1:0] x);
    logic signed [CoordW-1:0] r;
    if (x > SatHi) begin
      r = {1'b0, {(CoordW - 1){1'b1}}};
    end else if (x < SatLo) begin
      r = {1'b1, {(CoordW - 1){1'b0}}};
    end else begin
      r = x[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/eti_cfg_regs.sv
// ----------------------------------------------------------------------------
// eti_cfg_regs
// Register port holding the iteration limit, with read back.
// ----------------------------------------------------------------------------
module eti_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [eti_pkg::PaddrW-1:0]  paddr,
  input  logic [eti_pkg::PdataW-1:0]  pwdata,
  output logic [eti_pkg::PdataW-1:0]  prdata,
  output logic                        pready,
  output logic [eti_pkg::CntW-1:0]    max_iter_o
);
  import eti_pkg::*;

  logic [CntW-1:0]    max_iter_q;
  logic [RegIdxW-1:0] reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PaddrW-1:2];
  assign wr_en   = psel && penable && pwrite && pready && (reg_idx == RegMaxIter);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MaxIterInit;
    end else if (wr_en) begin
      max_iter_q <= pwdata[CntW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == RegMaxIter) begin
      prdata = PdataW'(max_iter_q);
    end
  end

  assign max_iter_o = max_iter_q;

endmodule

// File: rtl/escape_time_iterator_top.sv
// ----------------------------------------------------------------------------
// escape_time_iterator_top
// Mandelbrot escape-time iteration on one point, shared 32x32 multiplier.
//
//   channel  | dir | content
//   s_axis   | in  | tdata: c_real, c_imag
//   m_axis   | out | tdata: iteration_count, z_real, z_imag; tuser: escaped
//   apb      | in  | max_iterations at byte address 0
//
// one pass runs three products through the single multiplier
// (a*a, b*b, a*b) and then, unless the point is done, one update step
// asynchronous active-low reset; limit resets to 256
// a finished result waits in the output register while the next point
// is taken; the sequencer stalls only if that register is still full
// ----------------------------------------------------------------------------
module escape_time_iterator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // c_real [30:0], c_imag [61:31]
  input  logic [eti_pkg::InTdataW-1:0]   s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // iteration_count [15:0], z_real [47:16], z_imag [79:48]
  output logic [eti_pkg::OutTdataW-1:0]  m_axis_tdata,
  // escaped [0]
  output logic                           m_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [eti_pkg::PaddrW-1:0]     paddr,
  input  logic [eti_pkg::PdataW-1:0]     pwdata,
  output logic [eti_pkg::PdataW-1:0]     prdata,
  output logic                           pready
);
  import eti_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AA,
    ST_BB,
    ST_AB,
    ST_UPD,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   m_valid_q;
  logic   m_valid_d;

  logic [CntW-1:0]            max_iter;
  logic signed [CW-1:0]       cr_q, ci_q;
  logic signed [CoordW-1:0]   za_q, zb_q;
  logic signed [ProdW-1:0]    p_q, q_q, r_q;
  logic [CntW-1:0]            passes_q;
  logic                       esc_q;
  logic [CntW-1:0]            res_cnt_q;
  logic signed [CoordW-1:0]   res_re_q, res_im_q;
  logic                       res_esc_q;

  logic signed [CoordW-1:0]   op_a, op_b;
  logic signed [ProdW-1:0]    prod;
  logic [ProdW-1:0]           mag;
  logic                       escape_hit;
  logic                       limit_hit;
  logic signed [ProdW-1:0]    diff;
  logic signed [ProdW-1:0]    re_sh, im_sh;
  logic signed [SumW-1:0]     re_sum, im_sum;
  logic                       in_xfer;
  logic                       out_free;

  eti_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_iter_o (max_iter)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_valid_d     = ((state_q == ST_FIN) && out_free) || (m_valid_q && !m_axis_tready);

  // shared multiplier operand select
  always_comb begin
    op_a = za_q;
    op_b = za_q;
    case (state_q)
      ST_AA: begin
        op_a = za_q;
        op_b = za_q;
      end
      ST_BB: begin
        op_a = zb_q;
        op_b = zb_q;
      end
      ST_AB: begin
        op_a = za_q;
        op_b = zb_q;
      end
      default: begin
        op_a = za_q;
        op_b = za_q;
      end
    endcase
  end

  assign prod = op_a * op_b;

  assign mag        = $unsigned(p_q) + $unsigned(q_q);
  assign escape_hit = !EscNever && (mag > EscLimit);
  assign limit_hit  = (passes_q == max_iter);

  assign diff   = p_q - q_q;
  assign re_sh  = diff >>> FracBits;
  assign im_sh  = r_q >>> (FracBits - 1);
  assign re_sum = SumW'(re_sh) + SumW'(cr_q);
  assign im_sum = SumW'(im_sh) + SumW'(ci_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            state_q <= ST_AA;
          end
        end
        ST_AA:  state_q <= ST_BB;
        ST_BB:  state_q <= ST_AB;
        ST_AB: begin
          if (escape_hit || limit_hit) begin
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: state_q <= ST_AA;
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cr_q     <= s_axis_tdata[CW-1:0];
          ci_q     <= s_axis_tdata[2*CW-1:CW];
          za_q     <= '0;
          zb_q     <= '0;
          passes_q <= '0;
          esc_q    <= 1'b0;
        end
      end
      ST_AA: p_q <= prod;
      ST_BB: q_q <= prod;
      ST_AB: begin
        r_q   <= prod;
        esc_q <= escape_hit;
      end
      ST_UPD: begin
        za_q     <= sat_coord(re_sum);
        zb_q     <= sat_coord(im_sum);
        passes_q <= passes_q + CntW'(1);
      end
      ST_FIN: begin
        if (out_free) begin
          res_cnt_q <= esc_q ? (passes_q - CntW'(1)) : passes_q;
          res_re_q  <= za_q;
          res_im_q  <= zb_q;
          res_esc_q <= esc_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = res_esc_q;
  assign m_axis_tdata  = OutTdataW'({res_im_q, res_re_q, res_cnt_q});

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == ST_AA)
    else $error("accepted point did not start a pass");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input ready while iterating");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result loaded outside finish state");

  a_escape_needs_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && esc_q) |-> passes_q != '0)
    else $error("escape flagged before any pass");
`endif

endmodule
